// ===== hdl/motor_command_sequencer_with_ramp_core_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the motor command sequencer
// Short forms for concurrent assertions on the common clock and reset.
// ----------------------------------------------------------------------------
`ifndef MOTOR_COMMAND_SEQUENCER_WITH_RAMP_CORE_MACROS_SVH
`define MOTOR_COMMAND_SEQUENCER_WITH_RAMP_CORE_MACROS_SVH

// Assertion on an explicit clock and active-low reset.
`define MCSR_ASSERT_AT(name, clk, rstn, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Assertion on the block clock clk_i and reset rst_ni.
`define MCSR_ASSERT(name, prop, msg) `MCSR_ASSERT_AT(name, clk_i, rst_ni, prop, msg)

`endif

// ===== hdl/mcsr_pkg.sv =====
// ----------------------------------------------------------------------------
// Motor command sequencer package
// Field widths, key and command codes, and the controller/datapath interface.
// ----------------------------------------------------------------------------
package mcsr_pkg;

  localparam int SPEED_W   = 7;
  localparam int KEY_W     = 8;
  localparam int CMD_W     = 3;
  localparam int CFG_IDX_W = 2;

  localparam int RAMP_LENGTH_DEF = 10;

  // Key codes (ASCII).
  localparam logic [KEY_W-1:0] KEY_STOP   = 8'd115;
  localparam logic [KEY_W-1:0] KEY_FWD    = 8'd119;
  localparam logic [KEY_W-1:0] KEY_BACK   = 8'd120;
  localparam logic [KEY_W-1:0] KEY_FASTER = 8'd105;
  localparam logic [KEY_W-1:0] KEY_SLOWER = 8'd106;
  localparam logic [KEY_W-1:0] KEY_QUIT   = 8'd113;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_SPEED   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_INCREMENT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_CEILING   = 2'd2;

  localparam logic [SPEED_W-1:0] DEFAULT_SPEED_RST   = 7'd50;
  localparam logic [SPEED_W-1:0] SPEED_INCREMENT_RST = 7'd5;
  localparam logic [SPEED_W-1:0] SPEED_CEILING_RST   = 7'd100;

  typedef enum logic [CMD_W-1:0] {
    CMD_SPEED = 3'd0,
    CMD_STOP  = 3'd1,
    CMD_FWD   = 3'd2,
    CMD_BACK  = 3'd3,
    CMD_QUIT  = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    DIR_STOP = 2'd0,
    DIR_FWD  = 2'd1,
    DIR_BACK = 2'd2
  } dir_e;

  // Datapath operations issued by the controller.
  typedef enum logic [3:0] {
    DP_NONE,
    DP_STOP,
    DP_FASTER,
    DP_SLOWER,
    DP_GO,
    DP_REVERSE,
    DP_ACC_DEC,
    DP_ACC_CLR,
    DP_ACC_INC
  } dp_op_e;

  // Source of the speed value of an emitted command.
  typedef enum logic [1:0] {
    VSEL_ZERO,
    VSEL_SPEED,
    VSEL_RAMP
  } vsel_e;

  typedef struct packed {
    dp_op_e op;
    dir_e   dir;
  } dp_cmd_t;

  typedef struct packed {
    dir_e dir;
  } dp_status_t;

  typedef struct packed {
    logic  valid;
    cmd_e  cmd;
    vsel_e vsel;
    logic  last;
  } emit_t;

endpackage

// ===== hdl/mcsr_dp.sv =====
// ----------------------------------------------------------------------------
// Motor command sequencer datapath
// Configuration registers, speed and direction state, and the ramp unit.
// ----------------------------------------------------------------------------
module mcsr_dp #(
  parameter int RAMP_LENGTH = mcsr_pkg::RAMP_LENGTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [mcsr_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [mcsr_pkg::SPEED_W-1:0]        cfg_data_i,
  input  mcsr_pkg::dp_cmd_t                   dp_cmd_i,
  input  mcsr_pkg::vsel_e                     vsel_i,
  output mcsr_pkg::dp_status_t                status_o,
  output logic [mcsr_pkg::SPEED_W-1:0]        value_o
);
  import mcsr_pkg::*;

  // The accumulator holds speed * step; the reciprocal is exact for every
  // accumulator value, so the quotient needs no correction.
  localparam int FULL_SCALE = (1 << SPEED_W) - 1;
  localparam int ACC_W     = $clog2(FULL_SCALE * RAMP_LENGTH + 1);
  localparam int SH        = ACC_W + $clog2(RAMP_LENGTH + 1) + 1;
  localparam int PROD_W    = ACC_W + SH + 1;
  localparam logic [SH:0] RECIP = (SH+1)'(((1 << SH) + RAMP_LENGTH - 1) / RAMP_LENGTH);

  logic [SPEED_W-1:0] def_speed_q, inc_q, ceil_q;
  logic [SPEED_W-1:0] speed_q, speed_d;
  dir_e               dir_q, dir_d;
  logic [ACC_W-1:0]   acc_q, acc_d;
  logic [SPEED_W:0]   sum;
  logic [PROD_W-1:0]  prod;
  logic [SPEED_W-1:0] ramp_val;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      def_speed_q <= DEFAULT_SPEED_RST;
      inc_q       <= SPEED_INCREMENT_RST;
      ceil_q      <= SPEED_CEILING_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_DEFAULT_SPEED:   def_speed_q <= cfg_data_i;
        REG_SPEED_INCREMENT: inc_q       <= cfg_data_i;
        REG_SPEED_CEILING:   ceil_q      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    speed_d = speed_q;
    dir_d   = dir_q;
    acc_d   = acc_q;
    sum     = {1'b0, speed_q} + {1'b0, inc_q};
    case (dp_cmd_i.op)
      DP_STOP: begin
        speed_d = '0;
        dir_d   = DIR_STOP;
      end
      DP_FASTER: begin
        if (sum > {1'b0, ceil_q}) begin
          speed_d = ceil_q;
        end else begin
          speed_d = sum[SPEED_W-1:0];
        end
      end
      DP_SLOWER: begin
        if (inc_q >= speed_q) begin
          speed_d = '0;
          dir_d   = DIR_STOP;
        end else begin
          speed_d = speed_q - inc_q;
        end
      end
      DP_GO: begin
        dir_d = dp_cmd_i.dir;
        if (speed_q == '0) begin
          speed_d = def_speed_q;
        end
      end
      DP_REVERSE: begin
        dir_d = dp_cmd_i.dir;
        acc_d = ACC_W'(speed_q * RAMP_LENGTH);
      end
      DP_ACC_DEC: acc_d = acc_q - ACC_W'(speed_q);
      DP_ACC_CLR: acc_d = '0;
      DP_ACC_INC: acc_d = acc_q + ACC_W'(speed_q);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_q <= DEFAULT_SPEED_RST;
      dir_q   <= DIR_STOP;
    end else begin
      speed_q <= speed_d;
      dir_q   <= dir_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  // Division of the accumulator by the ramp length as a reciprocal multiply.
  assign prod     = PROD_W'(acc_q) * PROD_W'(RECIP);
  assign ramp_val = prod[SH +: SPEED_W];

  always_comb begin
    case (vsel_i)
      VSEL_SPEED: value_o = speed_q;
      VSEL_RAMP:  value_o = ramp_val;
      default:    value_o = '0;
    endcase
  end

  assign status_o.dir = dir_q;

endmodule

// ===== hdl/mcsr_ctrl.sv =====
// ----------------------------------------------------------------------------
// Motor command sequencer controller
// Decodes keys and steps through the command run of each key.
// ----------------------------------------------------------------------------
`include "motor_command_sequencer_with_ramp_core_macros.svh"

module mcsr_ctrl #(
  parameter int RAMP_LENGTH = mcsr_pkg::RAMP_LENGTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [mcsr_pkg::KEY_W-1:0]    key_code_i,
  input  logic                          adv_i,
  input  mcsr_pkg::dp_status_t          status_i,
  output mcsr_pkg::dp_cmd_t             dp_cmd_o,
  output mcsr_pkg::emit_t               emit_o
);
  import mcsr_pkg::*;

  localparam int CNT_W = $clog2(RAMP_LENGTH + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(RAMP_LENGTH);

  typedef enum logic [3:0] {
    S_IDLE,
    S_ZERO,
    S_TAIL,
    S_DIRC,
    S_SPD,
    S_RDOWN,
    S_RSTOP,
    S_RDIR,
    S_RUP
  } state_e;

  state_e           state_q;
  cmd_e             cmd_q;
  logic [CNT_W-1:0] cnt_q;
  logic             accept;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && (state_q == S_IDLE);

  // Datapath command: state updates at key acceptance, accumulator steps
  // while a ramp advances.
  always_comb begin
    dp_cmd_o.op  = DP_NONE;
    dp_cmd_o.dir = DIR_STOP;
    if (accept) begin
      case (key_code_i)
        KEY_STOP:   dp_cmd_o.op = DP_STOP;
        KEY_FASTER: dp_cmd_o.op = DP_FASTER;
        KEY_SLOWER: dp_cmd_o.op = DP_SLOWER;
        KEY_FWD: begin
          dp_cmd_o.dir = DIR_FWD;
          dp_cmd_o.op  = (status_i.dir == DIR_BACK) ? DP_REVERSE : DP_GO;
        end
        KEY_BACK: begin
          dp_cmd_o.dir = DIR_BACK;
          dp_cmd_o.op  = (status_i.dir == DIR_FWD) ? DP_REVERSE : DP_GO;
        end
        default: ;
      endcase
    end else if (adv_i) begin
      case (state_q)
        S_RDOWN: if (cnt_q != '0) dp_cmd_o.op = DP_ACC_DEC;
        S_RSTOP: dp_cmd_o.op = DP_ACC_CLR;
        S_RUP:   if (cnt_q != CNT_MAX) dp_cmd_o.op = DP_ACC_INC;
        default: ;
      endcase
    end
  end

  always_comb begin
    emit_o.valid = 1'b1;
    emit_o.cmd   = CMD_SPEED;
    emit_o.vsel  = VSEL_ZERO;
    emit_o.last  = 1'b0;
    case (state_q)
      S_ZERO:  ;
      S_TAIL: begin
        emit_o.cmd  = cmd_q;
        emit_o.last = 1'b1;
      end
      S_DIRC:  emit_o.cmd = cmd_q;
      S_SPD: begin
        emit_o.vsel = VSEL_SPEED;
        emit_o.last = 1'b1;
      end
      S_RDOWN: emit_o.vsel = VSEL_RAMP;
      S_RSTOP: emit_o.cmd = CMD_STOP;
      S_RDIR:  emit_o.cmd = cmd_q;
      S_RUP: begin
        emit_o.vsel = VSEL_RAMP;
        emit_o.last = (cnt_q == CNT_MAX);
      end
      default: emit_o.valid = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cmd_q   <= CMD_SPEED;
      cnt_q   <= '0;
    end else if (accept) begin
      case (key_code_i)
        KEY_STOP: begin
          cmd_q   <= CMD_STOP;
          state_q <= S_ZERO;
        end
        KEY_QUIT: begin
          cmd_q   <= CMD_QUIT;
          state_q <= S_ZERO;
        end
        KEY_FWD: begin
          cmd_q   <= CMD_FWD;
          cnt_q   <= CNT_MAX;
          state_q <= (status_i.dir == DIR_BACK) ? S_RDOWN : S_DIRC;
        end
        KEY_BACK: begin
          cmd_q   <= CMD_BACK;
          cnt_q   <= CNT_MAX;
          state_q <= (status_i.dir == DIR_FWD) ? S_RDOWN : S_DIRC;
        end
        KEY_FASTER: if (status_i.dir != DIR_STOP) state_q <= S_SPD;
        KEY_SLOWER: state_q <= S_SPD;
        default: ;
      endcase
    end else if (adv_i) begin
      case (state_q)
        S_ZERO: state_q <= S_TAIL;
        S_TAIL: state_q <= S_IDLE;
        S_DIRC: state_q <= S_SPD;
        S_SPD:  state_q <= S_IDLE;
        S_RDOWN: begin
          if (cnt_q == '0) begin
            state_q <= S_RSTOP;
          end else begin
            cnt_q <= cnt_q - 1'b1;
          end
        end
        S_RSTOP: state_q <= S_RDIR;
        S_RDIR: begin
          cnt_q   <= '0;
          state_q <= S_RUP;
        end
        S_RUP: begin
          if (cnt_q == CNT_MAX) begin
            state_q <= S_IDLE;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  `MCSR_ASSERT(a_cnt_range, cnt_q <= CNT_MAX, "ramp step count out of range")
  `MCSR_ASSERT(a_hold_on_stall, (state_q != S_IDLE && !adv_i) |=> $stable(state_q), "sequencer moved while output was full")
  `MCSR_ASSERT(a_ramp_end, (state_q == S_RUP && adv_i && cnt_q == CNT_MAX) |=> (state_q == S_IDLE), "ramp up did not end the run")

endmodule

// ===== hdl/motor_command_sequencer_with_ramp_core.sv =====
// ----------------------------------------------------------------------------
// Motor command sequencer with speed ramp
// A key's first command passes the controller state register, then the output
// register. Commands leave one per cycle unless the output stalls; a new key
// waits until the current run ends. A reversal yields 2*RAMP_LENGTH+4 commands.
// Reset: asynchronous, active low; speed 50, stopped, registers at defaults.
// ----------------------------------------------------------------------------
module motor_command_sequencer_with_ramp_core #(
  parameter int RAMP_LENGTH = mcsr_pkg::RAMP_LENGTH_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Configuration write port.
  input  logic                               cfg_we_i,
  input  logic [mcsr_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [mcsr_pkg::SPEED_W-1:0]       cfg_data_i,
  // Key input channel.
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [mcsr_pkg::KEY_W-1:0]         key_code_i,
  // Motor command output channel.
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [mcsr_pkg::CMD_W-1:0]         motor_command_o,
  output logic [mcsr_pkg::SPEED_W-1:0]       speed_value_o,
  output logic                               last_of_run_o
);
  import mcsr_pkg::*;

  // The controller decodes each key, updates the datapath state and then
  // walks through the command run one command per cycle unless stalled.
  // The datapath owns the configuration registers, the current speed and
  // direction, and the ramp accumulator with its divide-by-ramp-length unit.

  dp_cmd_t            dp_cmd;
  dp_status_t         status;
  emit_t              emit;
  logic [SPEED_W-1:0] value;
  logic               adv;

  logic               out_valid_q;
  cmd_e               cmd_q;
  logic [SPEED_W-1:0] value_q;
  logic               last_q;

  // The output register can take a new command when it is empty or when
  // its current command is being transferred in this cycle. The sequencer
  // advances only then, so no command is lost or repeated under stall.
  assign adv = !out_valid_q || !out_stall_i;

  mcsr_ctrl #(
    .RAMP_LENGTH(RAMP_LENGTH)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .key_code_i (key_code_i),
    .adv_i      (adv),
    .status_i   (status),
    .dp_cmd_o   (dp_cmd),
    .emit_o     (emit)
  );

  mcsr_dp #(
    .RAMP_LENGTH(RAMP_LENGTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .dp_cmd_i   (dp_cmd),
    .vsel_i     (emit.vsel),
    .status_o   (status),
    .value_o    (value)
  );

  // Output register: valid is control state, the payload is loaded only
  // when a command enters, so a stalled command holds its value.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= emit.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && emit.valid) begin
      cmd_q   <= emit.cmd;
      value_q <= value;
      last_q  <= emit.last;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign motor_command_o = cmd_q;
  assign speed_value_o   = value_q;
  assign last_of_run_o   = last_q;

endmodule

// ===== test/motor_command_sequencer_with_ramp_core_test.sv =====
// ----------------------------------------------------------------------------
// Testbench for the motor command sequencer with speed ramp
// Sends key codes into the sequencer and checks every motor command it
// emits against a predictor of speed, direction and ramp behavior. The
// predictor runs in lockstep with the key transfers. Both channels are
// throttled at random except in the last phase, and the configuration
// registers are changed between phases while the block is idle.
// ----------------------------------------------------------------------------
module motor_command_sequencer_with_ramp_core_test;
  import mcsr_pkg::*;

  localparam int RAMP_LEN      = RAMP_LENGTH_DEF;
  // A reversal yields 2*RAMP_LEN+4 commands; this margin comfortably covers one.
  localparam int SETTLE_CYCLES = 2 * RAMP_LEN + 10;
  localparam int CYCLE_LIMIT   = 1000000;

  // One emitted motor command as the predictor sees it.
  typedef struct packed {
    cmd_e               cmd;
    logic [SPEED_W-1:0] speed;
    logic               last;
  } motor_cmd_t;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [SPEED_W-1:0] cfg_data_i;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [KEY_W-1:0]   key_code_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [CMD_W-1:0]   motor_command_o;
  logic [SPEED_W-1:0] speed_value_o;
  logic               last_of_run_o;

  motor_command_sequencer_with_ramp_core #(
    .RAMP_LENGTH(RAMP_LEN)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .key_code_i     (key_code_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .motor_command_o(motor_command_o),
    .speed_value_o  (speed_value_o),
    .last_of_run_o  (last_of_run_o)
  );

  // Predictor state: a private copy of the registers and of the motor state.
  logic [SPEED_W-1:0] cfg_default;
  logic [SPEED_W-1:0] cfg_step;
  logic [SPEED_W-1:0] cfg_ceiling;
  logic [SPEED_W-1:0] motor_speed;
  dir_e               motor_dir;

  // Commands still owed by the block, oldest first, and the run of the key
  // that is being predicted right now.
  motor_cmd_t pending_cmds[$];
  motor_cmd_t key_run[$];

  int          mismatches;
  int unsigned cycles;
  // When clear, neither side throttles; the last part of the run uses this.
  bit          idle_on;

  initial begin
    clk_i = 1'b0;
  end

  always begin
    #10 clk_i = ~clk_i;
  end

  // Watchdog: a hung handshake or a lost command ends the run here.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("motor_command_sequencer_with_ramp_core_test NOT OK");
      $finish;
    end
  end

  // The receiver stalls at random, in bursts of random length.
  int stall_left;

  always @(posedge clk_i) begin
    if (!idle_on) begin
      out_stall_i <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
    end else if ($urandom_range(0, 5) == 0) begin
      out_stall_i <= 1'b1;
      stall_left = $urandom_range(0, 12);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Appends one command to the run of the current key; values are cut to the
  // speed width, as the block does.
  function automatic void add_cmd(input cmd_e c, input int v);
    motor_cmd_t m;
    m.cmd   = c;
    m.speed = v[SPEED_W-1:0];
    m.last  = 1'b0;
    key_run.push_back(m);
  endfunction

  // Forward or backward key. Turning around from the opposite direction ramps
  // the speed down to zero, stops, turns and ramps back up without touching
  // the stored speed, even when it is zero. Any other case emits the
  // direction and then the speed, with a zero speed replaced by the default.
  task automatic predict_go(input dir_e new_dir, input dir_e opposite);
    cmd_e dir_cmd;
    int   s;
    dir_cmd = (new_dir == DIR_FWD) ? CMD_FWD : CMD_BACK;
    if (motor_dir == opposite) begin
      for (s = RAMP_LEN; s >= 0; s--) begin
        add_cmd(CMD_SPEED, (int'(motor_speed) * s) / RAMP_LEN);
      end
      add_cmd(CMD_STOP, 0);
      add_cmd(dir_cmd, 0);
      for (s = 0; s <= RAMP_LEN; s++) begin
        add_cmd(CMD_SPEED, (int'(motor_speed) * s) / RAMP_LEN);
      end
    end else begin
      add_cmd(dir_cmd, 0);
      if (motor_speed == '0) begin
        motor_speed = cfg_default;
      end
      add_cmd(CMD_SPEED, int'(motor_speed));
    end
    motor_dir = new_dir;
  endtask

  // Works out the commands that one accepted key causes and queues them.
  task automatic predict_key(input logic [KEY_W-1:0] key);
    int s;
    key_run.delete();
    case (key)
      KEY_STOP: begin
        add_cmd(CMD_SPEED, 0);
        add_cmd(CMD_STOP, 0);
        motor_speed = '0;
        motor_dir   = DIR_STOP;
      end
      KEY_FWD: begin
        predict_go(DIR_FWD, DIR_BACK);
      end
      KEY_BACK: begin
        predict_go(DIR_BACK, DIR_FWD);
      end
      KEY_FASTER: begin
        // A speed already above the ceiling also drops to it.
        s = int'(motor_speed) + int'(cfg_step);
        if (s > int'(cfg_ceiling)) begin
          s = int'(cfg_ceiling);
        end
        motor_speed = s[SPEED_W-1:0];
        if (motor_dir != DIR_STOP) begin
          add_cmd(CMD_SPEED, int'(motor_speed));
        end
      end
      KEY_SLOWER: begin
        // Reaching zero stops the motors without a stop command.
        if (cfg_step >= motor_speed) begin
          motor_speed = '0;
        end else begin
          motor_speed = motor_speed - cfg_step;
        end
        add_cmd(CMD_SPEED, int'(motor_speed));
        if (motor_speed == '0) begin
          motor_dir = DIR_STOP;
        end
      end
      KEY_QUIT: begin
        add_cmd(CMD_SPEED, 0);
        add_cmd(CMD_QUIT, 0);
      end
      default: begin
      end
    endcase
    if (key_run.size() > 0) begin
      key_run[key_run.size() - 1].last = 1'b1;
    end
    foreach (key_run[i]) begin
      pending_cmds.push_back(key_run[i]);
    end
  endtask

  // Every command transfer is matched against the oldest owed command. The
  // outputs are sampled at the edge, so they hold their values from before it.
  always @(posedge clk_i) begin : check_cmd
    motor_cmd_t got;
    motor_cmd_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.cmd   = cmd_e'(motor_command_o);
      got.speed = speed_value_o;
      got.last  = last_of_run_o;
      if (pending_cmds.size() == 0) begin
        if (mismatches < 10) begin
          $display("cycle %0d: unexpected command %0d speed %0d last %0d",
                   cycles, got.cmd, got.speed, got.last);
        end
        mismatches++;
      end else begin
        want = pending_cmds.pop_front();
        if (got.cmd !== want.cmd || got.speed !== want.speed ||
            got.last !== want.last) begin
          if (mismatches < 10) begin
            $display("cycle %0d: command/speed/last expected %0d/%0d/%0d, got %0d/%0d/%0d",
                     cycles, want.cmd, want.speed, want.last,
                     got.cmd, got.speed, got.last);
          end
          mismatches++;
        end
      end
    end
  end

  // Offers one key and holds it until the block takes it. Valid is left high
  // when no gap follows, so back-to-back keys keep a steady valid.
  task automatic send_key(input logic [KEY_W-1:0] key);
    in_valid_i <= 1'b1;
    key_code_i <= key;
    do begin
      @(posedge clk_i);
    end while (in_stall_o);
    predict_key(key);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
  endtask

  // Drops valid, waits for every owed command, then gives a key that emits
  // nothing time to leave the block before anything else happens.
  task automatic wait_until_idle();
    in_valid_i <= 1'b0;
    while (pending_cmds.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Writes one register; the predictor takes the new value at the same edge.
  // The enable drops for one cycle afterwards, so writes never overlap.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [SPEED_W-1:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_DEFAULT_SPEED:   cfg_default = value;
      REG_SPEED_INCREMENT: cfg_step    = value;
      REG_SPEED_CEILING:   cfg_ceiling = value;
      default: begin
      end
    endcase
    @(posedge clk_i);
  endtask

  // Register values for the random phases lean on the extremes of the field.
  function automatic logic [SPEED_W-1:0] pick_setting();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return 7'd100;
      2:       return '1;
      default: return SPEED_W'($urandom_range(0, 100));
    endcase
  endfunction

  // Random keys, weighted toward direction keys so that reversals and their
  // ramps are frequent. Arbitrary codes are mixed in; only known keys are counted.
  task automatic send_random_keys(input int key_count);
    int               sent;
    logic [KEY_W-1:0] key;
    sent = 0;
    while (sent < key_count) begin
      case ($urandom_range(0, 9))
        0, 1:    key = KEY_FWD;
        2, 3:    key = KEY_BACK;
        4:       key = KEY_STOP;
        5, 6:    key = KEY_FASTER;
        7:       key = KEY_SLOWER;
        8:       key = KEY_QUIT;
        default: key = KEY_W'($urandom_range(0, 255));
      endcase
      if (key == KEY_FWD || key == KEY_BACK || key == KEY_STOP ||
          key == KEY_FASTER || key == KEY_SLOWER || key == KEY_QUIT) begin
        sent++;
      end
      send_key(key);
    end
  endtask

  // Every key with the reset settings: faster while stopped, both reversals,
  // a repeated direction, start from zero speed, quit and unknown codes,
  // including the all-zero and all-one codes.
  task automatic test_reset_keys();
    send_key(KEY_FASTER);
    send_key(KEY_FWD);
    send_key(KEY_FASTER);
    send_key(KEY_BACK);
    send_key(KEY_FWD);
    send_key(KEY_FWD);
    send_key(KEY_BACK);
    send_key(KEY_BACK);
    send_key(KEY_STOP);
    send_key(KEY_FWD);
    send_key(KEY_QUIT);
    send_key(KEY_SLOWER);
    send_key(8'h00);
    send_key(8'hFF);
    send_key(8'h61);
  endtask

  // Register extremes: a zero default gives a moving motor at speed zero and
  // so a reversal of all zeros, a full-scale step hits the ceiling and then
  // slows straight to a stop, a ceiling below the speed pulls it down, and a
  // zero step leaves the speed alone.
  task automatic test_register_extremes();
    wait_until_idle();
    write_reg(REG_DEFAULT_SPEED, '0);
    write_reg(REG_SPEED_INCREMENT, '1);
    write_reg(REG_SPEED_CEILING, '1);
    send_key(KEY_STOP);
    send_key(KEY_FWD);
    send_key(KEY_BACK);
    send_key(KEY_FASTER);
    send_key(KEY_FWD);
    send_key(KEY_SLOWER);
    wait_until_idle();
    write_reg(REG_SPEED_CEILING, 7'd20);
    write_reg(REG_DEFAULT_SPEED, '1);
    send_key(KEY_FWD);
    send_key(KEY_FASTER);
    wait_until_idle();
    write_reg(REG_SPEED_INCREMENT, '0);
    send_key(KEY_SLOWER);
    send_key(KEY_FASTER);
  endtask

  // Several phases of random keys, each under freshly drawn register values.
  task automatic test_random_settings();
    repeat (4) begin
      wait_until_idle();
      write_reg(REG_DEFAULT_SPEED, pick_setting());
      write_reg(REG_SPEED_INCREMENT, pick_setting());
      write_reg(REG_SPEED_CEILING, pick_setting());
      send_random_keys(85);
    end
  endtask

  // Back to the reset settings with both channels running flat out.
  task automatic test_steady_stream();
    wait_until_idle();
    idle_on = 1'b0;
    write_reg(REG_DEFAULT_SPEED, DEFAULT_SPEED_RST);
    write_reg(REG_SPEED_INCREMENT, SPEED_INCREMENT_RST);
    write_reg(REG_SPEED_CEILING, SPEED_CEILING_RST);
    send_random_keys(85);
  endtask

  initial begin
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = '0;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    key_code_i  = '0;
    out_stall_i = 1'b0;
    stall_left  = 0;
    mismatches  = 0;
    cycles      = 0;
    idle_on     = 1'b1;
    cfg_default = DEFAULT_SPEED_RST;
    cfg_step    = SPEED_INCREMENT_RST;
    cfg_ceiling = SPEED_CEILING_RST;
    motor_speed = DEFAULT_SPEED_RST;
    motor_dir   = DIR_STOP;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_keys();
    test_register_extremes();
    test_random_settings();
    test_steady_stream();
    wait_until_idle();

    if (mismatches == 0 && pending_cmds.size() == 0) begin
      $display("motor_command_sequencer_with_ramp_core_test OK");
    end else begin
      $display("motor_command_sequencer_with_ramp_core_test NOT OK");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/mcsr_pkg.sv
hdl/mcsr_dp.sv
hdl/mcsr_ctrl.sv
hdl/motor_command_sequencer_with_ramp_core.sv
test/motor_command_sequencer_with_ramp_core_test.sv
